### rtl/hcbp_pkg.sv
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int SYM_W        = 8;
	localparam int WORD_BITS    = 32;
	localparam int CNT_W        = 5;
	localparam int LEN_W        = 6;
	localparam int ENTRY_W      = LEN_W + WORD_BITS;
	localparam int OUTQ_DEPTH   = 4;
	localparam int OUTQ_PTR_W   = 2;
	localparam int OUTQ_CNT_W   = 3;

	localparam logic [LEN_W-1:0] MAX_CODE_LEN = LEN_W'(32);
	localparam logic [LEN_W-1:0] WORD_LEN     = LEN_W'(WORD_BITS);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RES_WORD  = 2'd0,
		RES_ERROR = 2'd1,
		RES_FLUSH = 2'd2
	} res_kind_t;

	// one queue entry; a flush entry expands into two transfers
	typedef struct packed {
		res_kind_t             kind;
		logic [WORD_BITS-1:0]  word;
		logic [CNT_W-1:0]      count;
	} res_entry_t;

	// item in flight between lookup and pack
	typedef struct packed {
		logic  valid;
		op_t   op;
		logic  hit;
	} pack_item_t;

	function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
		logic [2*WORD_BITS-1:0] m;
		begin
			m = ((2*WORD_BITS)'(1) << n) - (2*WORD_BITS)'(1);
			return m[WORD_BITS-1:0];
		end
	endfunction

endpackage

### rtl/huffman_code_bit_packer.sv
`timescale 1ns / 1ps

// channel  handshake            payload
// input    in_valid/in_ready    operation, symbol, code_bits, code_length
// output   out_valid/out_ready  out_word, is_length, last, error
//
// one item per cycle while in_ready is high; an encode reads its table entry into the RAM
// output register as it is accepted, and the packer then folds it into the accumulator,
// writing any full word into the result queue; a flush leaves as two output transfers
// reset clears entry valid marks, accumulator, count, error stop and the result queue at once
// a four-entry result queue absorbs output stalls; input stalls when it may fill

module huffman_code_bit_packer
	import hcbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [WORD_BITS-1:0] code_bits,
	input  logic [LEN_W-1:0]     code_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] out_word,
	output logic                 is_length,
	output logic                 last,
	output logic                 error
);

	logic [SYMBOL_COUNT-1:0] entry_valid_q;
	pack_item_t              item_s1;
	logic                    accept;
	op_t                     op;
	logic [LEN_W-1:0]        len_sat;
	logic                    load;
	logic                    lookup;
	logic [ENTRY_W-1:0]      rd_entry;
	logic                    res_wr;
	res_entry_t              res;
	logic [OUTQ_CNT_W-1:0]   fill;

	assign op       = op_t'(operation);
	assign in_ready = ((OUTQ_CNT_W+1)'(fill) + (OUTQ_CNT_W+1)'(item_s1.valid))
		< (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
	assign accept   = in_valid && in_ready;
	assign load     = accept && (op == OP_LOAD);
	assign lookup   = accept && (op == OP_ENCODE);
	assign len_sat  = (code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : code_length;

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (load),
		.wr_addr (symbol),
		.wr_data ({len_sat, code_bits}),
		.rd_en   (lookup),
		.rd_addr (symbol),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			item_s1       <= '0;
		end else begin
			if (load) begin
				entry_valid_q[symbol] <= 1'b1;
			end
			item_s1.valid <= accept;
			item_s1.op    <= op;
			item_s1.hit   <= entry_valid_q[symbol];
		end
	end

	hcbp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.entry  (rd_entry),
		.res_wr (res_wr),
		.res    (res)
	);

	hcbp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_wr),
		.wr_data   (res),
		.fill      (fill),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.is_length (is_length),
		.last      (last),
		.error     (error)
	);

endmodule

### rtl/hcbp_ram.sv
`timescale 1ns / 1ps

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/hcbp_packer.sv
`timescale 1ns / 1ps

module hcbp_packer
	import hcbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pack_item_t           item,
	input  logic [ENTRY_W-1:0]   entry,
	output logic                 res_wr,
	output res_entry_t           res
);

	logic [WORD_BITS-1:0]   acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   stop_q;

	logic [LEN_W-1:0]       len;
	logic [WORD_BITS-1:0]   code;
	logic [LEN_W-1:0]       total;
	logic [CNT_W-1:0]       keep;
	logic [LEN_W-1:0]       room;
	logic [2*WORD_BITS-1:0] acc_wide;
	logic [2*WORD_BITS-1:0] acc_up_len;
	logic [2*WORD_BITS-1:0] acc_up_room;
	logic [WORD_BITS-1:0]   code_down;
	logic                   fills;

	logic [WORD_BITS-1:0]   acc_d;
	logic [CNT_W-1:0]       cnt_d;
	logic                   stop_d;

	always_comb begin
		len         = entry[ENTRY_W-1 -: LEN_W];
		if (len > WORD_LEN) begin
			len = WORD_LEN;
		end
		code        = entry[WORD_BITS-1:0] & low_mask(len);
		total       = LEN_W'(cnt_q) + len;
		fills       = (total >= WORD_LEN);
		keep        = CNT_W'(total - WORD_LEN);
		room        = WORD_LEN - LEN_W'(cnt_q);
		acc_wide    = (2*WORD_BITS)'(acc_q);
		acc_up_len  = acc_wide << len;
		acc_up_room = acc_wide << room;
		code_down   = code >> keep;
	end

	always_comb begin
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		stop_d     = stop_q;
		res_wr     = 1'b0;
		res.kind   = RES_WORD;
		res.word   = acc_q;
		res.count  = cnt_q;
		if (item.valid) begin
			case (item.op)
				OP_ENCODE: begin
					if (!stop_q) begin
						if (!item.hit) begin
							stop_d   = 1'b1;
							res_wr   = 1'b1;
							res.kind = RES_ERROR;
						end else if (!fills) begin
							acc_d = acc_up_len[WORD_BITS-1:0] | code;
							cnt_d = CNT_W'(total);
						end else begin
							res_wr   = 1'b1;
							res.kind = RES_WORD;
							res.word = acc_up_room[WORD_BITS-1:0] | code_down;
							acc_d    = code & low_mask(LEN_W'(keep));
							cnt_d    = keep;
						end
					end
				end
				OP_FLUSH: begin
					res_wr   = 1'b1;
					res.kind = RES_FLUSH;
					acc_d    = '0;
					cnt_d    = '0;
					stop_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			stop_q <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			stop_q <= stop_d;
		end
	end

endmodule

### rtl/hcbp_outq.sv
`timescale 1ns / 1ps

module hcbp_outq
	import hcbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  res_entry_t            wr_data,
	output logic [OUTQ_CNT_W-1:0] fill,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  out_word,
	output logic                  is_length,
	output logic                  last,
	output logic                  error
);

	res_entry_t            slot_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] head_q;
	logic [OUTQ_PTR_W-1:0] tail_q;
	logic [OUTQ_CNT_W-1:0] fill_q;
	logic                  phase_q;
	res_entry_t            head;
	logic                  xfer;
	logic                  pop;

	assign fill      = fill_q;
	assign head      = slot_q[head_q];
	assign out_valid = (fill_q != '0);
	assign xfer      = out_valid && out_ready;
	assign pop       = xfer && ((head.kind != RES_FLUSH) || phase_q);

	always_comb begin
		out_word  = head.word;
		is_length = 1'b0;
		last      = 1'b0;
		error     = 1'b0;
		case (head.kind)
			RES_ERROR: begin
				out_word = '0;
				error    = 1'b1;
			end
			RES_FLUSH: begin
				if (phase_q) begin
					out_word  = WORD_BITS'(head.count);
					is_length = 1'b1;
					last      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			if (wr_en) begin
				tail_q <= tail_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				head_q  <= head_q + OUTQ_PTR_W'(1);
				phase_q <= 1'b0;
			end else if (xfer) begin
				phase_q <= 1'b1;
			end
			fill_q <= fill_q + OUTQ_CNT_W'(wr_en) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

### verif/bit_pack_check_pkg.sv
`timescale 1ns / 1ps

package bit_pack_check_pkg;
	import hcbp_pkg::*;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 is_length;
		logic                 last;
		logic                 error;
	} stream_result_t;

	class bit_stream_scoreboard;
		logic [WORD_BITS-1:0] code_tab [SYMBOL_COUNT];
		logic [LEN_W-1:0]     len_tab [SYMBOL_COUNT];
		bit                   known [SYMBOL_COUNT];
		logic [WORD_BITS-1:0] acc;
		logic [CNT_W-1:0]     cnt;
		bit                   halted;
		stream_result_t       pending_words [$];
		int unsigned          fail_count;

		function new();
			foreach (known[i]) begin
				known[i] = 1'b0;
			end
			acc = '0;
			cnt = '0;
			halted = 1'b0;
			fail_count = 0;
		endfunction

		function void push_result(logic [WORD_BITS-1:0] w, logic isl, logic lst, logic err);
			stream_result_t r;
			r.word = w;
			r.is_length = isl;
			r.last = lst;
			r.error = err;
			pending_words.push_back(r);
		endfunction

		// one accepted input transfer; queues the words it should produce
		function void note_accepted_item(logic [1:0] op, logic [SYM_W-1:0] sym,
				logic [WORD_BITS-1:0] bits, logic [LEN_W-1:0] len);
			int unsigned n;
			int unsigned total;
			int unsigned keep;
			logic [2*WORD_BITS-1:0] code;
			logic [2*WORD_BITS-1:0] wide;
			case (op)
				OP_LOAD: begin
					code_tab[sym] = bits;
					len_tab[sym] = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
					known[sym] = 1'b1;
				end
				OP_ENCODE: begin
					if (!halted) begin
						if (!known[sym]) begin
							halted = 1'b1;
							push_result('0, 1'b0, 1'b0, 1'b1);
						end else begin
							n = len_tab[sym];
							if (n > WORD_BITS)
								n = WORD_BITS;
							code = 64'(code_tab[sym]) & ((64'd1 << n) - 64'd1);
							total = cnt + n;
							if (total < WORD_BITS) begin
								acc = WORD_BITS'((64'(acc) << n) | code);
								cnt = CNT_W'(total);
							end else begin
								keep = total - WORD_BITS;
								// empty accumulator shifts fully out of the word
								wide = (64'(acc) << (WORD_BITS - cnt)) | (code >> keep);
								push_result(wide[WORD_BITS-1:0], 1'b0, 1'b0, 1'b0);
								acc = WORD_BITS'(code & ((64'd1 << keep) - 64'd1));
								cnt = CNT_W'(keep);
							end
						end
					end
				end
				OP_FLUSH: begin
					push_result(acc, 1'b0, 1'b0, 1'b0);
					push_result(WORD_BITS'(cnt), 1'b1, 1'b1, 1'b0);
					acc = '0;
					cnt = '0;
					halted = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, logic [WORD_BITS-1:0] want,
				logic [WORD_BITS-1:0] got);
			if (got !== want) begin
				fail_count++;
				$display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_transfer(logic [WORD_BITS-1:0] w, logic isl, logic lst, logic err);
			stream_result_t want;
			if (pending_words.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected transfer expected none actual word=%h is_length=%b last=%b error=%b",
					$time, w, isl, lst, err);
				return;
			end
			want = pending_words.pop_front();
			compare_field("out_word", want.word, w);
			compare_field("is_length", WORD_BITS'(want.is_length), WORD_BITS'(isl));
			compare_field("last", WORD_BITS'(want.last), WORD_BITS'(lst));
			compare_field("error", WORD_BITS'(want.error), WORD_BITS'(err));
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

endpackage

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import hcbp_pkg::*;
	import bit_pack_check_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           operation;
	logic [SYM_W-1:0]     symbol;
	logic [WORD_BITS-1:0] code_bits;
	logic [LEN_W-1:0]     code_length;
	logic                 out_valid;
	logic                 out_ready;
	logic [WORD_BITS-1:0] out_word;
	logic                 is_length;
	logic                 last;
	logic                 error;

	bit_stream_scoreboard sb;
	int unsigned          send_idle_pct;
	int unsigned          recv_idle_pct;
	bit                   hold_req;
	int unsigned          cycles;
	logic [SYM_W-1:0]     loaded_syms [$];

	huffman_code_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.is_length  (is_length),
		.last       (last),
		.error      (error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// output side: check transfers, random stalls and a long hold-off on each request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_transfer(out_word, is_length, last, error);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic [WORD_BITS-1:0] bits, input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		symbol <= sym;
		code_bits <= bits;
		code_length <= len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == OP_LOAD && !sb.known[sym])
			loaded_syms.push_back(sym);
		sb.note_accepted_item(op, sym, bits, len);
	endtask

	task automatic send_random_item();
		int unsigned r;
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] len;
		r = $urandom_range(99);
		sym = SYM_W'($urandom_range(255));
		case ($urandom_range(9))
			0: len = '0;
			1: len = LEN_W'($urandom_range(63, 33));
			2: len = MAX_CODE_LEN;
			3, 4: len = LEN_W'($urandom_range(31, 17));
			default: len = LEN_W'($urandom_range(16, 1));
		endcase
		if (r < 15 || loaded_syms.size() == 0) begin
			send_item(OP_LOAD, sym, $urandom, len);
		end else if (r < 89) begin
			// mostly known symbols, now and then any symbol
			if ($urandom_range(49) != 0)
				sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
			send_item(OP_ENCODE, sym, $urandom, len);
		end else if (r < 97) begin
			send_item(OP_FLUSH, sym, $urandom, len);
		end else begin
			send_item(OP_UNUSED, sym, $urandom, len);
		end
	endtask

	initial begin
		int unsigned i;
		sb = new();
		send_idle_pct = 25;
		recv_idle_pct = 68;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_LOAD;
		symbol <= '0;
		code_bits <= '0;
		code_length <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
		send_item(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_LOAD, 8'hFF, 32'h0, 6'd0);
		send_item(OP_LOAD, 8'h01, 32'hA5A5_0F0F, 6'd63);
		send_item(OP_LOAD, 8'h02, 32'hFFFF_FFF5, 6'd3);
		send_item(OP_LOAD, 8'h03, 32'h1, 6'd1);
		send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'h02, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'h01, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
		send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);
		send_item(OP_LOAD, 8'h04, 32'h0FFF_FFFF, 6'd28);
		send_item(OP_ENCODE, 8'h04, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);
		send_item(OP_LOAD, 8'h05, 32'h8000_0001, 6'd33);
		send_item(OP_ENCODE, 8'h05, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'hC3, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);

		hold_req = 1'b1;
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random_item();
		send_idle_pct = 68;
		recv_idle_pct = 25;
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random_item();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		for (i = 0; i < PHASE_ITEMS; i++)
			send_random_item();
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
rtl/hcbp_pkg.sv
rtl/hcbp_ram.sv
rtl/hcbp_packer.sv
rtl/hcbp_outq.sv
rtl/huffman_code_bit_packer.sv
verif/bit_pack_check_pkg.sv
verif/tb.sv
